[sv/lkvc_pkg.sv]
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared types and constants for the lru key-value cache
// ----------------------------------------------------------------------------
package lkvc_pkg;

  // config port
  localparam int PADDR_BITS = 3;
  localparam int REG_INDEX_BITS = PADDR_BITS - 2;
  localparam logic [REG_INDEX_BITS-1:0] REG_CAPACITY = '0;

  localparam int CAP_BITS = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  localparam int WORD_BITS = 32;
  localparam logic [WORD_BITS-1:0] MISS_VALUE = '1;
  localparam logic [WORD_BITS-1:0] SET_VALUE = '0;

  typedef enum logic {
    KIND_GET = 1'b0,
    KIND_SET = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                       kind;
    logic signed [WORD_BITS-1:0] key;
    logic signed [WORD_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    logic                        hit;
    logic signed [WORD_BITS-1:0] read_value;
  } rsp_t;

endpackage

[sv/lru_key_value_cache_core.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// fully associative key-value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// Takes one get or set word per cycle unless results stall and returns one
// result word each, in order, via the input and result registers. All ENTRIES
// keys are compared in parallel while a word is in the input register; the
// same cycle updates the data, valid bits and per-entry recency ranks, so the
// next word already sees the new state and the rate is one word per clock,
// set by that single compare-and-update pass. Recency is a rank per valid
// entry, 0 most recent and occupied-1 least recent; the victim is the valid
// entry holding the highest rank. A set on a new key takes the lowest free
// entry while occupancy is below capacity, otherwise the victim. The capacity
// register (address 0, reset 16) is clamped to 1..ENTRIES; the user must
// write it only while the cache is idle, which the block does not enforce.
// Entry storage needs no clearing: reset drops the valid bits only.
module lru_key_value_cache_core #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // config port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lkvc_pkg::PADDR_BITS-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  // request channel
  input  logic                                req_valid,
  output logic                                req_ready,
  input  lkvc_pkg::req_t                      req,
  // result channel
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output lkvc_pkg::rsp_t                      rsp
);
  import lkvc_pkg::*;

  localparam int RANK_BITS = $clog2(ENTRIES);
  localparam int CNT_BITS  = $clog2(ENTRIES + 1);
  localparam int CMP_BITS  = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

  // config register
  logic [CAP_BITS-1:0]  capacity;
  logic                 cfg_write;
  logic [CMP_BITS-1:0]  eff_cap;

  // input register
  req_t                 req_q;
  logic                 req_q_valid;
  logic                 advance;

  // entry storage
  logic [KEY_BITS-1:0]  entry_key  [ENTRIES];
  logic [WORD_BITS-1:0] entry_data [ENTRIES];
  logic [RANK_BITS-1:0] entry_rank [ENTRIES];
  logic [ENTRIES-1:0]   entry_valid;
  logic [CNT_BITS-1:0]  occupied;

  // lookup results
  logic [KEY_BITS-1:0]  key_ext;
  logic [RANK_BITS-1:0] last_rank;
  logic                 hit;
  logic [ENTRIES-1:0]   match_oh;
  logic [WORD_BITS-1:0] match_data;
  logic [RANK_BITS-1:0] match_rank;
  logic [ENTRIES-1:0]   free_oh;
  logic [ENTRIES-1:0]   victim_oh;

  // update control
  logic                 is_set;
  logic                 do_fill;
  logic                 do_update;
  logic [ENTRIES-1:0]   target_oh;
  logic [CNT_BITS-1:0]  old_rank;
  rsp_t                 rsp_next;

  // ---------------------------------------------------------------- config
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_BITS-1:2] == REG_CAPACITY) begin
      prdata[CAP_BITS-1:0] = capacity;
    end
  end

  // capacity clamped to 1..ENTRIES
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CMP_BITS'(1);
    end else if (CMP_BITS'(capacity) > CMP_BITS'(ENTRIES)) begin
      eff_cap = CMP_BITS'(ENTRIES);
    end else begin
      eff_cap = CMP_BITS'(capacity);
    end
  end

  // ---------------------------------------------------------------- handshake
  // stage 2 moves when the result register is empty or being drained
  assign advance   = req_q_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !req_q_valid || advance;

  // ---------------------------------------------------------------- key
  generate
    if (KEY_BITS > WORD_BITS) begin : g_key_wide
      assign key_ext = {{(KEY_BITS - WORD_BITS){req_q.key[WORD_BITS-1]}}, req_q.key};
    end else begin : g_key_narrow
      assign key_ext = req_q.key[KEY_BITS-1:0];
    end
  endgenerate

  // least recent rank is occupied-1; only used when occupied is nonzero
  assign last_rank = RANK_BITS'(occupied - CNT_BITS'(1));

  lkvc_lookup #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_lookup (
    .key         (key_ext),
    .entry_key   (entry_key),
    .entry_data  (entry_data),
    .entry_rank  (entry_rank),
    .entry_valid (entry_valid),
    .last_rank   (last_rank),
    .hit         (hit),
    .match_oh    (match_oh),
    .match_data  (match_data),
    .match_rank  (match_rank),
    .free_oh     (free_oh),
    .victim_oh   (victim_oh)
  );

  // ---------------------------------------------------------------- update
  // fill ages every valid entry (old rank = occupied), replace promotes the
  // victim from the bottom, a hit promotes the matching entry
  assign is_set    = (req_q.kind == KIND_SET);
  assign do_fill   = is_set && !hit && (CMP_BITS'(occupied) < eff_cap);
  assign do_update = advance && (is_set || hit);

  always_comb begin
    if (hit) begin
      target_oh = match_oh;
      old_rank  = CNT_BITS'(match_rank);
    end else if (do_fill) begin
      target_oh = free_oh;
      old_rank  = occupied;
    end else begin
      target_oh = victim_oh;
      old_rank  = occupied - CNT_BITS'(1);
    end
  end

  always_comb begin
    rsp_next.hit = hit;
    if (is_set) begin
      rsp_next.read_value = SET_VALUE;
    end else if (hit) begin
      rsp_next.read_value = match_data;
    end else begin
      rsp_next.read_value = MISS_VALUE;
    end
  end

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= CAP_RESET;
      req_q_valid <= 1'b0;
      rsp_valid   <= 1'b0;
      entry_valid <= '0;
      occupied    <= '0;
    end else begin
      if (cfg_write && (paddr[PADDR_BITS-1:2] == REG_CAPACITY)) begin
        capacity <= pwdata[CAP_BITS-1:0];
      end
      if (req_ready) begin
        req_q_valid <= req_valid;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (advance && do_fill) begin
        entry_valid <= entry_valid | free_oh;
        occupied    <= occupied + CNT_BITS'(1);
      end
    end
  end

  // ---------------------------------------------------------------- payload regs
  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      req_q <= req;
    end
    if (advance) begin
      rsp <= rsp_next;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_update) begin
        if (target_oh[i]) begin
          entry_rank[i] <= '0;
        end else if (entry_valid[i] && (CNT_BITS'(entry_rank[i]) < old_rank)) begin
          entry_rank[i] <= entry_rank[i] + RANK_BITS'(1);
        end
      end
      if (advance && is_set && target_oh[i]) begin
        entry_key[i]  <= key_ext;
        entry_data[i] <= req_q.value;
      end
    end
  end

endmodule

[sv/lkvc_lookup.sv]
// ----------------------------------------------------------------------------
// lkvc_lookup
// parallel key match, free entry pick and lru victim pick
// ----------------------------------------------------------------------------
module lkvc_lookup #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32
) (
  input  logic [KEY_BITS-1:0]                 key,
  input  logic [KEY_BITS-1:0]                 entry_key  [ENTRIES],
  input  logic [lkvc_pkg::WORD_BITS-1:0]      entry_data [ENTRIES],
  input  logic [$clog2(ENTRIES)-1:0]          entry_rank [ENTRIES],
  input  logic [ENTRIES-1:0]                  entry_valid,
  input  logic [$clog2(ENTRIES)-1:0]          last_rank,
  output logic                                hit,
  output logic [ENTRIES-1:0]                  match_oh,
  output logic [lkvc_pkg::WORD_BITS-1:0]      match_data,
  output logic [$clog2(ENTRIES)-1:0]          match_rank,
  output logic [ENTRIES-1:0]                  free_oh,
  output logic [ENTRIES-1:0]                  victim_oh
);
  import lkvc_pkg::*;

  localparam int RANK_BITS = $clog2(ENTRIES);

  logic [ENTRIES-1:0] free_vec;

  // valid keys are unique, so at most one match
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_oh[i]  = entry_valid[i] && (entry_key[i] == key);
      victim_oh[i] = entry_valid[i] && (entry_rank[i] == last_rank);
    end
  end

  always_comb begin
    match_data = '0;
    match_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match_data = match_data | (entry_data[i] & {WORD_BITS{match_oh[i]}});
      match_rank = match_rank | (entry_rank[i] & {RANK_BITS{match_oh[i]}});
    end
  end

  // lowest invalid entry: isolate lowest set bit
  assign free_vec = ~entry_valid;
  assign free_oh  = free_vec & (~free_vec + ENTRIES'(1));
  assign hit      = |match_oh;

endmodule

[test/lkvc_checker.sv]
// ----------------------------------------------------------------------------
// lkvc_checker
// watches the request, result and config channels of the lru key-value cache,
// keeps its own copy of the cache contents and recency order, and compares
// every accepted result word with the oldest predicted word
// ----------------------------------------------------------------------------
module lkvc_checker #(
  parameter int ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lkvc_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                     pwdata,
  input  logic                            pready,
  input  logic                            req_valid,
  input  logic                            req_ready,
  input  lkvc_pkg::req_t                  req,
  input  logic                            rsp_valid,
  input  logic                            rsp_ready,
  input  lkvc_pkg::rsp_t                  rsp,
  output int                              fail_count,
  output int                              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import lkvc_pkg::*;

  logic [WORD_BITS-1:0] slot_key  [ENTRIES];
  logic [WORD_BITS-1:0] slot_data [ENTRIES];
  logic                 slot_valid[ENTRIES];
  int unsigned          slot_rank [ENTRIES];
  int unsigned          occupied;
  logic [CAP_BITS-1:0]  capacity;

  rsp_t expected_results[$];
  rsp_t want;
  int   errors = 0;

  // clamp to 1..ENTRIES
  function automatic int unsigned usable_capacity();
    if (capacity == 0) return 1;
    if (capacity > ENTRIES) return ENTRIES;
    return capacity;
  endfunction

  // entries more recent than the slot age by one
  function automatic void touch_slot(int slot);
    int unsigned old_rank;
    old_rank = slot_rank[slot];
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i] && i != slot && slot_rank[i] < old_rank)
        slot_rank[i]++;
    slot_rank[slot] = 0;
  endfunction

  function automatic rsp_t lru_access(req_t w);
    rsp_t r;
    int   found;
    int   free_slot;
    int   victim;
    found     = -1;
    free_slot = -1;
    victim    = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (found < 0 && slot_valid[i] && slot_key[i] == w.key)
        found = i;
    r.hit        = (found >= 0);
    r.read_value = SET_VALUE;

    if (w.kind == KIND_GET) begin
      if (found >= 0) begin
        r.read_value = slot_data[found];
        touch_slot(found);
      end else begin
        r.read_value = MISS_VALUE;
      end
      return r;
    end

    if (found >= 0) begin
      slot_data[found] = w.value;
      touch_slot(found);
      return r;
    end

    if (occupied < usable_capacity()) begin
      for (int i = 0; i < ENTRIES; i++)
        if (free_slot < 0 && !slot_valid[i])
          free_slot = i;
      if (free_slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++)
          if (slot_valid[i])
            slot_rank[i]++;
        slot_valid[free_slot] = 1'b1;
        slot_key[free_slot]   = w.key;
        slot_data[free_slot]  = w.value;
        slot_rank[free_slot]  = 0;
        occupied++;
        return r;
      end
    end

    // replace the least recently used valid entry
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim]))
        victim = i;
    if (victim >= 0) begin
      slot_key[victim]  = w.key;
      slot_data[victim] = w.value;
      touch_slot(victim);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_rank[i]  = 0;
      end
      occupied = 0;
      capacity = CAP_RESET;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[PADDR_BITS-1:2] == REG_CAPACITY)
        capacity = pwdata[CAP_BITS-1:0];

      if (rsp_valid && rsp_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result word with none expected: hit=%0b read_value=%h",
                   $time, rsp.hit, rsp.read_value);
        end else begin
          want = expected_results.pop_front();
          if (rsp.hit !== want.hit) begin
            errors++;
            $display("%0t: hit mismatch: expected %0b, actual %0b",
                     $time, want.hit, rsp.hit);
          end
          if (rsp.read_value !== want.read_value) begin
            errors++;
            $display("%0t: read_value mismatch: expected %h, actual %h",
                     $time, want.read_value, rsp.read_value);
          end
        end
      end

      if (req_valid && req_ready)
        expected_results.push_back(lru_access(req));
    end
    fail_count  <= errors;
    outstanding <= expected_results.size();
  end

endmodule

[test/tb_lru_key_value_cache_core.sv]
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_core
// drives get and set words into the lru key-value cache through a series of
// capacity settings, with random stalls on both channels, and reports the
// verdict from the checker's failure count
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lkvc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 7;
  localparam int PHASE_WORDS = 270;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  req_t                  req = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  rsp_t                  rsp;

  int fail_count;
  int outstanding;
  int cycles = 0;
  bit idle_on = 1'b1;

  // keys drawn from a small pool so gets and sets keep hitting
  logic [31:0] key_pool[32];
  int          pool_span = 8;

  always #5 clk = ~clk;

  lru_key_value_cache_core dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  lkvc_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side back-pressure: random stall bursts
  initial begin
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 4) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // two-phase config write, setup then access; called at a clock edge
  task automatic write_capacity(input logic [31:0] cap);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= cap;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // offers one word, maybe after an idle burst, and returns at its acceptance
  task automatic send_word(input kind_t kind, input logic [31:0] key,
                           input logic [31:0] value);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= req_t'{kind: kind, key: key, value: value};
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic send_random_word();
    kind_t       kind;
    logic [31:0] key;
    logic [31:0] value;
    kind = $urandom_range(0, 1) ? KIND_SET : KIND_GET;
    // mostly pooled keys, now and then a fresh full-width key
    if ($urandom_range(0, 99) < 85)
      key = key_pool[$urandom_range(0, pool_span - 1)];
    else
      key = $urandom;
    case ($urandom_range(0, 9))
      0:       value = '1;
      1:       value = '0;
      default: value = $urandom;
    endcase
    send_word(kind, key, value);
  endtask

  // let the cache run dry before touching the config register
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    logic [4:0] phase_cap[PHASES];
    int         usable;

    // capacity walk: full at 2, growth to 4, lowered to 3, growth to 8,
    // above the entry count, lowered to 1 with a full cache, back to 16
    phase_cap = '{5'd2, 5'd4, 5'd3, 5'd8, 5'd17, 5'd1, 5'd16};

    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'h8000_0000;
    key_pool[2] = 32'h7FFF_FFFF;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 32; i++) key_pool[i] = $urandom;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset capacity, empty cache: a get has to miss
    send_word(KIND_GET, 32'h0000_0000, 32'h0000_0000);
    drain();

    // capacity 1: fill the only entry, hit it, then push it out
    write_capacity(32'd1);
    send_word(KIND_SET, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(KIND_GET, 32'h8000_0000, 32'h0000_0000);
    send_word(KIND_SET, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(KIND_GET, 32'h8000_0000, 32'h0000_0000);
    send_word(KIND_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    drain();

    // capacity 0 acts as 1; a stored all-ones value reads back as a hit
    write_capacity(32'd0);
    send_word(KIND_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    drain();

    // capacity 31 acts as 16: fill, update in place, get ignores its value
    write_capacity(32'd31);
    send_word(KIND_SET, 32'h0000_0000, 32'h0000_0000);
    send_word(KIND_SET, 32'hFFFF_FFFF, 32'h1234_5678);
    send_word(KIND_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(KIND_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // random phases, each under its own capacity
    for (int p = 0; p < PHASES; p++) begin
      write_capacity({27'd0, phase_cap[p]});
      usable    = (phase_cap[p] == 0) ? 1 : (phase_cap[p] > 16) ? 16 : phase_cap[p];
      pool_span = (usable + 4 > 32) ? 32 : usable + 4;
      // one quiet phase early on and another at the end
      idle_on   = (p != 2) && (p != PHASES - 1);
      repeat (PHASE_WORDS) send_random_word();
      drain();
    end

    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
